[hdl/window_at_most_k_distinct_count_assert.svh]
// Assertion macros used by the port-level checker of the distinct-count window block
`ifndef WINDOW_AT_MOST_K_DISTINCT_COUNT_ASSERT_SVH
`define WINDOW_AT_MOST_K_DISTINCT_COUNT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define WKD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define WKD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/wkd_pkg.sv]
// Package: types, constants and sizes for the distinct-count window block
`timescale 1ns / 1ps

package wkd_pkg;

	localparam int MAX_LEN_DEF  = 65536;
	localparam int ID_COUNT_DEF = 65536;

	localparam int VAL_W = 16;
	localparam int LIM_W = 17;
	localparam int EH_W  = 17;
	localparam int TOT_W = 32;
	localparam int ALU_W = 33;

	localparam logic [LIM_W-1:0] LIMIT_RST = LIM_W'(1);
	localparam logic [EH_W-1:0]  EH_MAX    = '1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_ADD_RD,
		S_ADD_WR,
		S_CHECK,
		S_DROP_A,
		S_DROP_B,
		S_DROP_C,
		S_FINISH,
		S_DRAIN
	} state_t;

	typedef enum logic [1:0] {
		PH_EVICT,
		PH_SHRINK,
		PH_DRAIN
	} phase_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t           op;
		logic [ALU_W-1:0]  a;
		logic [ALU_W-1:0]  b;
	} alu_req_t;

endpackage

[hdl/wkd_ram.sv]
// Simple dual-port RAM: one write port, one registered read port
`timescale 1ns / 1ps

module wkd_ram import wkd_pkg::*; #(
	parameter int WIDTH = VAL_W,
	parameter int DEPTH = MAX_LEN_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[hdl/wkd_alu.sv]
// Shared add / subtract unit used for id reduction and total accumulation
`timescale 1ns / 1ps

module wkd_alu import wkd_pkg::*; (
	input  alu_req_t         req,
	output logic [ALU_W:0]   res
);

	// top bit is the carry on add, the borrow on subtract
	always_comb begin
		unique case (req.op)
			ALU_ADD: res = {1'b0, req.a} + {1'b0, req.b};
			ALU_SUB: res = {1'b0, req.a} - {1'b0, req.b};
			default: res = '0;
		endcase
	end

endmodule

[hdl/window_at_most_k_distinct_count.sv]
// Top level: streaming count of subarrays with at most a limit of distinct values
//
//   channel  direction  handshake             word
//   in       sink       in_valid / in_stall    value_id, last_item
//   out      source     out_valid / out_stall  ending_here, running_total,
//                                              overflow_flag, is_final
//   cfg      sink       cfg_wen                cfg_wdata (distinct_limit)
//
// Sequencing: an accepted word passes S_ADD_RD, S_ADD_WR, S_CHECK and S_FINISH, where its
//   result is registered; no new word is taken until the block is back in S_IDLE. Each
//   entry dropped over the limit adds S_DROP_A/B/C and S_CHECK, the entry evicted when the
//   window already holds MAX_LEN adds S_DROP_A/B/C first, and S_MOD reduces the id when
//   ID_COUNT < 65536. The steps follow from the single read/write port pair of the RAMs.
// After a word marked last the window drains, an entry per pass of S_DRAIN and S_DROP_A/B/C.
// Reset: a clearing pass writes the occurrence table one entry a cycle, all OCC_DEPTH
//   entries (65536 at default), with in_stall high; cfg writes are taken meanwhile.
// Stalls: a result waits in the output register; the next word is accepted while it
//   waits, and the sequencer holds in its final step only if a second result is ready.
`timescale 1ns / 1ps

module window_at_most_k_distinct_count import wkd_pkg::*; #(
	parameter int MAX_LEN  = MAX_LEN_DEF,
	parameter int ID_COUNT = ID_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [VAL_W-1:0] value_id,
	input  logic             last_item,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [EH_W-1:0]  ending_here,
	output logic [TOT_W-1:0] running_total,
	output logic             overflow_flag,
	output logic             is_final,
	input  logic             cfg_wen,
	input  logic [LIM_W-1:0] cfg_wdata
);

	// ids wider than the table need reducing modulo ID_COUNT
	localparam bit MOD_NEED  = (ID_COUNT < (1 << VAL_W));
	localparam int IDW       = MOD_NEED ? $clog2(ID_COUNT) : VAL_W;
	localparam int OCC_DEPTH = MOD_NEED ? ID_COUNT : (1 << VAL_W);
	localparam int MOD_STEPS = MOD_NEED ? (VAL_W + 1 - $clog2(ID_COUNT)) : 1;
	localparam int KW        = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
	localparam int PW        = $clog2(MAX_LEN);
	localparam int LW        = $clog2(MAX_LEN + 1);
	localparam int DCW       = (LW > LIM_W) ? LW : LIM_W;
	localparam int EHW       = (LW > EH_W) ? LW : EH_W;

	state_t state_q, state_d;
	phase_t phase_q;

	// per-sequence state
	logic [PW-1:0]    left_q;
	logic [PW-1:0]    wr_q;
	logic [LW-1:0]    right_q;
	logic [LW-1:0]    distinct_q;
	logic [TOT_W-1:0] total_q;
	logic [LW-1:0]    items_q;
	logic             ovf_q;
	logic [LIM_W-1:0] limit_q;
	logic [IDW-1:0]   clr_q;

	// per-word working registers
	logic [IDW-1:0]   id_q;
	logic             last_q;
	logic [VAL_W-1:0] modr_q;
	logic [KW-1:0]    k_q;
	logic [IDW-1:0]   drop_id_q;

	// output register
	logic             out_valid_q;
	logic [EH_W-1:0]  eh_q;
	logic [TOT_W-1:0] tot_q;
	logic             ovf_out_q;
	logic             fin_q;

	// RAM ports
	logic             win_we;
	logic [IDW-1:0]   win_rdata;
	logic             occ_we;
	logic [IDW-1:0]   occ_waddr;
	logic [LW-1:0]    occ_wdata;
	logic [IDW-1:0]   occ_raddr;
	logic [LW-1:0]    occ_rdata;

	alu_req_t         alu_req;
	logic [ALU_W:0]   alu_res;

	logic             out_free;
	logic             full_win;
	logic             over_lim;
	logic             alu_ge;
	logic [VAL_W-1:0] modr_nx;
	logic [TOT_W-1:0] tot_sat;
	logic [EH_W-1:0]  eh_sat;
	logic [PW-1:0]    left_nx;
	logic [PW-1:0]    wr_nx;
	logic [ALU_W-1:0] mod_sub;

	wkd_ram #(.WIDTH(IDW), .DEPTH(MAX_LEN)) u_win (
		.clk   (clk),
		.we    (win_we),
		.waddr (wr_q),
		.wdata (id_q),
		.raddr (left_q),
		.rdata (win_rdata)
	);

	wkd_ram #(.WIDTH(LW), .DEPTH(OCC_DEPTH)) u_occ (
		.clk   (clk),
		.we    (occ_we),
		.waddr (occ_waddr),
		.wdata (occ_wdata),
		.raddr (occ_raddr),
		.rdata (occ_rdata)
	);

	wkd_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	// output register frees up when empty or being taken this cycle
	assign out_free = !out_valid_q || !out_stall;
	assign full_win = (right_q == LW'(MAX_LEN));
	assign over_lim = (DCW'(distinct_q) > DCW'(limit_q)) && (right_q != '0);

	// restoring remainder step: subtract ID_COUNT shifted by k when it fits
	assign mod_sub = ALU_W'(ID_COUNT) << k_q;
	assign alu_ge  = !alu_res[ALU_W];
	assign modr_nx = alu_ge ? alu_res[VAL_W-1:0] : modr_q;

	// saturate the running total at all ones and the length at the field width
	assign tot_sat = alu_res[TOT_W] ? '1 : alu_res[TOT_W-1:0];
	assign eh_sat  = (EHW'(right_q) > EHW'(EH_MAX)) ? EH_MAX : EH_W'(right_q);

	assign left_nx = (left_q == PW'(MAX_LEN - 1)) ? '0 : left_q + PW'(1);
	assign wr_nx   = (wr_q == PW'(MAX_LEN - 1)) ? '0 : wr_q + PW'(1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == IDW'(OCC_DEPTH - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					if (MOD_NEED) state_d = S_MOD;
					else          state_d = full_win ? S_DROP_A : S_ADD_RD;
				end
			end
			S_MOD: begin
				if (k_q == '0) state_d = full_win ? S_DROP_A : S_ADD_RD;
			end
			S_ADD_RD: state_d = S_ADD_WR;
			S_ADD_WR: state_d = S_CHECK;
			S_CHECK:  state_d = over_lim ? S_DROP_A : S_FINISH;
			S_DROP_A: state_d = S_DROP_B;
			S_DROP_B: state_d = S_DROP_C;
			S_DROP_C: begin
				unique case (phase_q)
					PH_EVICT:  state_d = S_ADD_RD;
					PH_SHRINK: state_d = S_CHECK;
					PH_DRAIN:  state_d = S_DRAIN;
					default:   state_d = S_IDLE;
				endcase
			end
			S_FINISH: begin
				if (out_free) state_d = last_q ? S_DRAIN : S_IDLE;
			end
			S_DRAIN: state_d = (right_q != '0) ? S_DROP_A : S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// RAM, ALU and handshake controls
	always_comb begin
		in_stall     = (state_q != S_IDLE);
		win_we       = (state_q == S_ADD_WR);
		occ_we       = 1'b0;
		occ_waddr    = id_q;
		occ_wdata    = '0;
		occ_raddr    = (state_q == S_DROP_B) ? win_rdata : id_q;
		alu_req.op   = ALU_ADD;
		alu_req.a    = ALU_W'(total_q);
		alu_req.b    = ALU_W'(right_q);
		unique case (state_q)
			S_CLEAR: begin
				occ_we    = 1'b1;
				occ_waddr = clr_q;
			end
			S_MOD: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = ALU_W'(modr_q);
				alu_req.b  = mod_sub;
			end
			S_ADD_WR: begin
				occ_we    = 1'b1;
				occ_wdata = occ_rdata + LW'(1);
			end
			S_DROP_C: begin
				occ_we    = (occ_rdata != '0);
				occ_waddr = drop_id_q;
				occ_wdata = occ_rdata - LW'(1);
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			phase_q     <= PH_EVICT;
			clr_q       <= '0;
			left_q      <= '0;
			wr_q        <= '0;
			right_q     <= '0;
			distinct_q  <= '0;
			total_q     <= '0;
			items_q     <= '0;
			ovf_q       <= 1'b0;
			limit_q     <= LIMIT_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen) limit_q <= cfg_wdata;
			// the final step reloads the output register itself
			if (out_valid_q && !out_stall && state_q != S_FINISH) out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: clr_q <= clr_q + IDW'(1);
				S_IDLE: begin
					if (in_valid) begin
						phase_q <= PH_EVICT;
						// the word past MAX_LEN marks the sequence as too long
						if (items_q == LW'(MAX_LEN)) ovf_q   <= 1'b1;
						else                         items_q <= items_q + LW'(1);
					end
				end
				S_ADD_WR: begin
					wr_q    <= wr_nx;
					right_q <= right_q + LW'(1);
					if (occ_rdata == '0) distinct_q <= distinct_q + LW'(1);
					phase_q <= PH_SHRINK;
				end
				S_DROP_C: begin
					if (occ_rdata == LW'(1) && distinct_q != '0) begin
						distinct_q <= distinct_q - LW'(1);
					end
					left_q  <= left_nx;
					right_q <= right_q - LW'(1);
				end
				S_FINISH: begin
					if (out_free) begin
						total_q     <= tot_sat;
						out_valid_q <= 1'b1;
						phase_q     <= PH_DRAIN;
					end
				end
				S_DRAIN: begin
					// window empty: start the next sequence clean
					if (right_q == '0) begin
						left_q     <= '0;
						wr_q       <= '0;
						distinct_q <= '0;
						total_q    <= '0;
						items_q    <= '0;
						ovf_q      <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// word payload and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					id_q   <= value_id[IDW-1:0];
					last_q <= last_item;
					modr_q <= value_id;
					k_q    <= KW'(MOD_STEPS - 1);
				end
			end
			S_MOD: begin
				modr_q <= modr_nx;
				k_q    <= k_q - KW'(1);
				if (k_q == '0) id_q <= modr_nx[IDW-1:0];
			end
			S_DROP_B: drop_id_q <= win_rdata;
			S_FINISH: begin
				if (out_free) begin
					eh_q      <= eh_sat;
					tot_q     <= tot_sat;
					ovf_out_q <= ovf_q;
					fin_q     <= last_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign ending_here   = eh_q;
	assign running_total = tot_q;
	assign overflow_flag = ovf_out_q;
	assign is_final      = fin_q;

endmodule

[hdl/wkd_checker.sv]
// Port-level checker for the distinct-count window block, with its bind
`timescale 1ns / 1ps
`include "window_at_most_k_distinct_count_assert.svh"

module wkd_checker import wkd_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [EH_W-1:0]  ending_here,
	input logic [TOT_W-1:0] running_total,
	input logic             overflow_flag,
	input logic             is_final
);

	logic first_q;

	// track whether the next result opens a sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (out_valid && !out_stall) begin
			first_q <= is_final;
		end
	end

	`WKD_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted word did not make the block busy")

	`WKD_ASSERT_NOW(a_total_covers_len, out_valid, running_total >= TOT_W'(ending_here), "running total below the length of the word")

	`WKD_ASSERT_NOW(a_first_total, out_valid && first_q, running_total == TOT_W'(ending_here) && !overflow_flag, "first result of a sequence carries stale state")

	`WKD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(running_total) && $stable(ending_here), "stalled result changed")

endmodule

bind window_at_most_k_distinct_count wkd_checker u_wkd_checker (.*);

[tb/window_at_most_k_distinct_count_check.sv]
// Checker: predicts every result word of the distinct-count window and compares it
`timescale 1ns / 1ps

module window_at_most_k_distinct_count_check import wkd_pkg::*; #(
	parameter int MAX_LEN  = MAX_LEN_DEF,
	parameter int ID_COUNT = ID_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic [VAL_W-1:0] value_id,
	input  logic             last_item,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic [EH_W-1:0]  ending_here,
	input  logic [TOT_W-1:0] running_total,
	input  logic             overflow_flag,
	input  logic             is_final,
	input  logic             cfg_wen,
	input  logic [LIM_W-1:0] cfg_wdata,
	output int unsigned      fail_count,
	output int unsigned      pending_words
);

	typedef struct packed {
		logic [EH_W-1:0]  ending;
		logic [TOT_W-1:0] total;
		logic             ovf;
		logic             fin;
	} count_word_t;

	count_word_t expected_words[$];

	logic [VAL_W-1:0] win_ids [MAX_LEN];
	int unsigned      occ_count [ID_COUNT];
	int unsigned      win_head;
	int unsigned      win_len;
	int unsigned      distinct_cnt;
	int unsigned      seq_items;
	logic [TOT_W-1:0] seq_total;
	logic             seq_over;
	logic [LIM_W-1:0] limit_q;
	int unsigned      fails;

	// drop the leftmost window entry and its occurrence
	task automatic retire_oldest();
		int unsigned id;
		id = win_ids[win_head % MAX_LEN];
		id = id % ID_COUNT;
		if (occ_count[id] > 0) begin
			occ_count[id]--;
			if (occ_count[id] == 0 && distinct_cnt > 0)
				distinct_cnt--;
		end
		win_head = (win_head + 1) % MAX_LEN;
		win_len--;
	endtask

	task automatic predict_word(input logic [VAL_W-1:0] raw_id, input logic last,
			output count_word_t word);
		int unsigned      id;
		int unsigned      slot;
		logic [TOT_W:0]   sum;
		id = raw_id;
		id = id % ID_COUNT;
		if (seq_items != 32'hFFFF_FFFF)
			seq_items++;
		if (seq_items > MAX_LEN)
			seq_over = 1'b1;
		// full window: evict the oldest entry first
		if (win_len >= MAX_LEN)
			retire_oldest();
		slot = (win_head + win_len) % MAX_LEN;
		win_ids[slot] = id[VAL_W-1:0];
		win_len++;
		if (occ_count[id] == 0)
			distinct_cnt++;
		occ_count[id]++;
		while (distinct_cnt > limit_q && win_len > 0)
			retire_oldest();
		sum = seq_total + win_len;
		seq_total = (sum > {1'b0, {TOT_W{1'b1}}}) ? '1 : sum[TOT_W-1:0];
		word.ending = (win_len > EH_MAX) ? EH_MAX : win_len[EH_W-1:0];
		word.total  = seq_total;
		word.ovf    = seq_over;
		word.fin    = last;
		// end of sequence: drain and return to the clean state, keep the limit
		if (last) begin
			while (win_len > 0)
				retire_oldest();
			win_head     = 0;
			distinct_cnt = 0;
			seq_total    = '0;
			seq_items    = 0;
			seq_over     = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		count_word_t want;
		count_word_t got;
		if (!arst_n) begin
			foreach (occ_count[i])
				occ_count[i] = 0;
			win_head     = 0;
			win_len      = 0;
			distinct_cnt = 0;
			seq_items    = 0;
			seq_total    = '0;
			seq_over     = 1'b0;
			limit_q      = LIMIT_RST;
			fails        = 0;
			expected_words.delete();
			fail_count    <= 0;
			pending_words <= 0;
		end else begin
			if (cfg_wen === 1'b1)
				limit_q = cfg_wdata;
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				got = '{ending_here, running_total, overflow_flag, is_final};
				if (expected_words.size() == 0) begin
					if (fails < 10)
						$display("unexpected word: ending_here=%0d running_total=%0d overflow_flag=%0b is_final=%0b",
							got.ending, got.total, got.ovf, got.fin);
					fails++;
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						if (fails < 10)
							$display("mismatch: expected ending_here=%0d running_total=%0d overflow_flag=%0b is_final=%0b, got ending_here=%0d running_total=%0d overflow_flag=%0b is_final=%0b",
								want.ending, want.total, want.ovf, want.fin,
								got.ending, got.total, got.ovf, got.fin);
						fails++;
					end
				end
			end
			if (in_valid === 1'b1 && in_stall === 1'b0) begin
				predict_word(value_id, last_item, want);
				expected_words.push_back(want);
			end
			fail_count    <= fails;
			pending_words <= expected_words.size();
		end
	end

endmodule

[tb/window_at_most_k_distinct_count_tb.sv]
// Testbench top: drives words and limit writes into the block and gives the verdict
`timescale 1ns / 1ps

module window_at_most_k_distinct_count_tb;
	import wkd_pkg::*;

	localparam int          MAX_LEN          = MAX_LEN_DEF;
	localparam int unsigned CYCLE_LIMIT      = 5_000_000;
	localparam int unsigned RANDOM_PER_PHASE = 420;
	// one long run of a single id under a limit equal to the window depth
	localparam int unsigned LONG_RUN         = 40;
	localparam logic [VAL_W-1:0] CORNER_IDS [4] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF};

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	logic [VAL_W-1:0] value_id  = '0;
	logic             last_item = 1'b0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [EH_W-1:0]  ending_here;
	logic [TOT_W-1:0] running_total;
	logic             overflow_flag;
	logic             is_final;
	logic             cfg_wen   = 1'b0;
	logic [LIM_W-1:0] cfg_wdata = '0;

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned fail_count;
	int unsigned pending_words;
	// length of the latest sequence, bounds the drain the block does after it
	int unsigned last_seq_len   = 0;

	window_at_most_k_distinct_count DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.value_id      (value_id),
		.last_item     (last_item),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.ending_here   (ending_here),
		.running_total (running_total),
		.overflow_flag (overflow_flag),
		.is_final      (is_final),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata)
	);

	window_at_most_k_distinct_count_check #(
		.MAX_LEN  (MAX_LEN),
		.ID_COUNT (ID_COUNT_DEF)
	) count_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.value_id      (value_id),
		.last_item     (last_item),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.ending_here   (ending_here),
		.running_total (running_total),
		.overflow_flag (overflow_flag),
		.is_final      (is_final),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.pending_words (pending_words)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver: stall at random, one decision per cycle
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// watchdog: end the run if the block hangs
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("window_at_most_k_distinct_count_tb: FAIL");
		$finish;
	end

	// Offer one word and hold it until the block takes it. Idle cycles come first,
	// so the payload never changes while the word is stalled.
	task automatic send_word(input logic [VAL_W-1:0] id, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		value_id  <= id;
		last_item <= last;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
	endtask

	// Send one whole sequence; mark the final word as last.
	task automatic send_run(input logic [VAL_W-1:0] ids[$]);
		foreach (ids[k])
			send_word(ids[k], k == ids.size() - 1);
		last_seq_len = ids.size();
	endtask

	// Drop valid, wait for every expected word, then let the drain of the last
	// sequence run out, waiting in proportion to its window entries plus a margin.
	task automatic settle();
		int unsigned drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_words != 0)
			@(posedge clk);
		drain = (last_seq_len < MAX_LEN) ? last_seq_len : MAX_LEN;
		repeat (4 * drain + 32)
			@(posedge clk);
	endtask

	// Write the limit register only once the block is idle.
	task automatic write_limit(input logic [LIM_W-1:0] val);
		settle();
		cfg_wen   <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wen   <= 1'b0;
	endtask

	// One random sequence, sometimes under a new limit. Most sequences draw from
	// a small set of ids so the window grows and shrinks; the rest are spread
	// over the whole id range or stick to the corner ids.
	task automatic random_sequence(output int unsigned count);
		logic [VAL_W-1:0] ids[$];
		logic [VAL_W-1:0] base;
		int unsigned      len;
		int unsigned      alpha;
		int unsigned      style;
		int unsigned      pick;
		if ($urandom_range(1) == 1) begin
			pick = $urandom_range(99);
			if (pick < 70)
				write_limit(LIM_W'($urandom_range(1, 6)));
			else if (pick < 78)
				write_limit('0);
			else if (pick < 85)
				write_limit(LIM_W'(MAX_LEN));
			else if (pick < 90)
				write_limit('1);
			else
				write_limit(LIM_W'($urandom));
		end
		len   = ($urandom_range(99) < 85) ? $urandom_range(1, 24) : $urandom_range(25, 90);
		style = $urandom_range(99);
		base  = VAL_W'($urandom);
		alpha = $urandom_range(1, 8);
		repeat (len) begin
			if (style < 70)
				ids.push_back(base + VAL_W'($urandom_range(0, alpha - 1)));
			else if (style < 90)
				ids.push_back(VAL_W'($urandom));
			else
				ids.push_back(CORNER_IDS[$urandom_range(3)]);
		end
		send_run(ids);
		count = len;
	endtask

	initial begin : stimulus
		logic [VAL_W-1:0] ids[$];
		int unsigned      sent;
		int unsigned      n;
		int unsigned      i;

		// hold reset, then release it once
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// phase 1: sender idles rarely, receiver stalls mostly
		send_idle_pct  <= 6;
		recv_stall_pct <= 75;

		// directed: limit left at its reset value
		ids = '{16'd5, 16'd5, 16'd7, 16'd7, 16'd7};
		send_run(ids);
		// limit of zero: every word leaves the window at once
		write_limit('0);
		ids = '{16'h0000, 16'hFFFF};
		send_run(ids);
		// limit two: repeats and alternation between extremes
		write_limit(LIM_W'(2));
		ids = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'd3, 16'd3, 16'h0000, 16'd1};
		send_run(ids);
		// all ones limit: nothing is ever removed
		write_limit('1);
		ids = '{16'd1, 16'd2, 16'd3, 16'hFFFF};
		send_run(ids);
		// limit equal to the window depth, single-word sequence
		write_limit(LIM_W'(MAX_LEN));
		ids = '{16'd9};
		send_run(ids);
		write_limit(LIM_W'(3));
		ids = '{16'h8000, 16'h0001, 16'h8000, 16'h7FFF, 16'h0001, 16'h0002};
		send_run(ids);

		sent = 0;
		while (sent < RANDOM_PER_PHASE) begin
			random_sequence(n);
			sent += n;
		end

		// phase 2: sender idles mostly, receiver stalls rarely
		send_idle_pct  <= 75;
		recv_stall_pct <= 6;
		sent = 0;
		while (sent < RANDOM_PER_PHASE) begin
			random_sequence(n);
			sent += n;
		end

		// phase 3: no idling on either side
		send_idle_pct  <= 0;
		recv_stall_pct <= 0;
		sent = 0;
		while (sent < RANDOM_PER_PHASE / 2) begin
			random_sequence(n);
			sent += n;
		end

		// Long sequence of one id under a limit equal to the window depth: the window
		// only grows and the running total climbs as a triangle number.
		write_limit(LIM_W'(MAX_LEN));
		for (i = 0; i < LONG_RUN; i++)
			send_word(16'h1234, i == LONG_RUN - 1);
		last_seq_len = LONG_RUN;

		// short sequences after it show that the drain left the state clean
		sent = 0;
		while (sent < RANDOM_PER_PHASE / 2) begin
			random_sequence(n);
			sent += n;
		end

		settle();
		if (fail_count == 0 && pending_words == 0)
			$display("window_at_most_k_distinct_count_tb: PASS");
		else
			$display("window_at_most_k_distinct_count_tb: FAIL");
		$finish;
	end

endmodule
